### hdl/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg: shared constants for the two-level quantum round-robin core
// Field widths, command codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package qrr_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int TIME_BITS_DEF = 8;

    localparam int TASK_IDX_W = 3;
    localparam int FIELD_TIME_W = 8;
    localparam int QUANTUM_W = 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic CFG_IDX_QUANTUM_FIRST = 1'b0;
    localparam logic CFG_IDX_QUANTUM_SECOND = 1'b1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_FIRST_RST = 8'd2;
    localparam logic [QUANTUM_W-1:0] QUANTUM_SECOND_RST = 8'd4;

endpackage

### hdl/qrr_ifs.sv
// ----------------------------------------------------------------------------
// qrr_ifs: command and result channels of the round-robin core
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qrr_cmd_if;

    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [qrr_pkg::TASK_IDX_W-1:0]      task_index;
    logic [qrr_pkg::FIELD_TIME_W-1:0]    burst_time;

    modport source (output valid, command, task_index, burst_time, input ready);
    modport sink (input valid, command, task_index, burst_time, output ready);

endinterface

interface qrr_res_if;

    logic                                valid;
    logic                                ready;
    logic                                ran;
    logic [qrr_pkg::TASK_IDX_W-1:0]      served_task;
    logic [qrr_pkg::FIELD_TIME_W-1:0]    time_spent;
    logic [qrr_pkg::FIELD_TIME_W-1:0]    time_left;
    logic                                finished;
    logic                                all_done;

    modport source (
        output valid, ran, served_task, time_spent, time_left, finished, all_done,
        input ready
    );
    modport sink (
        input valid, ran, served_task, time_spent, time_left, finished, all_done,
        output ready
    );

endinterface

### hdl/qrr_slice_unit.sv
// ----------------------------------------------------------------------------
// qrr_slice_unit: shared quantum compare and subtract
// Picks the quantum for the entry's level and grants the lesser of it and
// the remaining time, using a single subtractor whose borrow is the compare.
// ----------------------------------------------------------------------------
module qrr_slice_unit #(
    parameter int TIME_BITS = qrr_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]            remaining,
    input  logic                            level,
    input  logic [qrr_pkg::QUANTUM_W-1:0]   quantum_first,
    input  logic [qrr_pkg::QUANTUM_W-1:0]   quantum_second,
    output logic [TIME_BITS-1:0]            spent,
    output logic [TIME_BITS-1:0]            left,
    output logic                            finished
);

    localparam int WW = (TIME_BITS > qrr_pkg::QUANTUM_W) ? TIME_BITS : qrr_pkg::QUANTUM_W;

    logic [qrr_pkg::QUANTUM_W-1:0] quantum_sel;
    logic [qrr_pkg::QUANTUM_W-1:0] quantum_eff;
    logic [WW-1:0]                 rem_wide;
    logic [WW-1:0]                 quantum_wide;
    logic [WW:0]                   diff;
    logic                          borrow;

    always_comb
    begin
        quantum_sel  = level ? quantum_second : quantum_first;
        quantum_eff  = (quantum_sel == '0) ? qrr_pkg::QUANTUM_W'(1) : quantum_sel;
        rem_wide     = WW'(remaining);
        quantum_wide = WW'(quantum_eff);
        diff         = {1'b0, rem_wide} - {1'b0, quantum_wide};
        borrow       = diff[WW];
        spent        = borrow ? remaining : TIME_BITS'(quantum_wide);
        left         = borrow ? '0 : TIME_BITS'(diff[WW-1:0]);
        finished     = (left == '0);
    end

endmodule

### hdl/two_level_quantum_round_robin_core.sv
// ----------------------------------------------------------------------------
// two_level_quantum_round_robin_core: two-level quantum round-robin scheduler
// Keeps a table of task entries; loads set burst times, steps serve the next
// entry with time left in wrapping index order and report the grant.
//
//   Channel   Direction  Transfer condition         Payload
//   cmd       in         cmd.valid && cmd.ready     command, task_index, burst_time
//   res       out        res.valid && res.ready     ran .. all_done
//   apb       in         psel && penable && pwrite  quantum_first, quantum_second
//
// A load completes in the cycle of its transfer and produces no result.
// A step starts a scan that visits table entries in wrapping index order,
// from 1 up to NUM_TASKS of them, since the scan reads one entry a cycle through the
// shared slice unit; with no time left anywhere the scan ends at once.
// After reset all entries are empty, the scan starts at entry 0 and the
// quanta are 2 and 4. A stalled result holds the scan in its last cycle.
// Loads are accepted while a result waits for its transfer.
// ----------------------------------------------------------------------------
module two_level_quantum_round_robin_core #(
    parameter int NUM_TASKS = qrr_pkg::NUM_TASKS_DEF,
    parameter int TIME_BITS = qrr_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    qrr_cmd_if.sink                         cmd,
    qrr_res_if.source                       res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qrr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qrr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qrr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int TIW = (IDX_W + 1 > qrr_pkg::TASK_IDX_W) ? IDX_W + 1 : qrr_pkg::TASK_IDX_W;
    localparam int BW = (TIME_BITS > qrr_pkg::FIELD_TIME_W) ? TIME_BITS : qrr_pkg::FIELD_TIME_W;

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_SCAN = 1'b1;

    logic                            state_reg, state_next;
    logic [TIME_BITS-1:0]            rem_reg [NUM_TASKS];
    logic [TIME_BITS-1:0]            rem_next [NUM_TASKS];
    logic [NUM_TASKS-1:0]            level_reg, level_next;
    logic [IDX_W-1:0]                next_ptr_reg, next_ptr_next;
    logic [IDX_W-1:0]                scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]                active_cnt_reg, active_cnt_next;
    logic [qrr_pkg::QUANTUM_W-1:0]   quantum_first_reg, quantum_first_next;
    logic [qrr_pkg::QUANTUM_W-1:0]   quantum_second_reg, quantum_second_next;

    logic                            res_valid_reg, res_valid_next;
    logic                            res_ran_reg, res_ran_next;
    logic [qrr_pkg::TASK_IDX_W-1:0]  res_task_reg, res_task_next;
    logic [qrr_pkg::FIELD_TIME_W-1:0] res_spent_reg, res_spent_next;
    logic [qrr_pkg::FIELD_TIME_W-1:0] res_left_reg, res_left_next;
    logic                            res_finished_reg, res_finished_next;
    logic                            res_all_done_reg, res_all_done_next;

    logic                            cmd_xfer;
    logic                            cfg_write;
    logic                            out_free;
    logic [TIW-1:0]                  tidx_wide;
    logic                            load_ok;
    logic [IDX_W-1:0]                load_idx;
    logic [BW-1:0]                   burst_wide;
    logic [BW-1:0]                   time_max_wide;
    logic [TIME_BITS-1:0]            load_val;
    logic [IDX_W-1:0]                scan_ptr_inc;
    logic [TIME_BITS-1:0]            scan_rem;
    logic                            scan_found;
    logic [TIME_BITS-1:0]            slice_spent;
    logic [TIME_BITS-1:0]            slice_left;
    logic                            slice_finished;

    qrr_slice_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_slice (
        .remaining      (scan_rem),
        .level          (level_reg[scan_ptr_reg]),
        .quantum_first  (quantum_first_reg),
        .quantum_second (quantum_second_reg),
        .spent          (slice_spent),
        .left           (slice_left),
        .finished       (slice_finished)
    );

    assign cmd.ready = (state_reg == STATE_IDLE);
    assign cmd_xfer = cmd.valid && cmd.ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;
    assign out_free = !res_valid_reg || res.ready;

    assign tidx_wide = TIW'(cmd.task_index);
    assign load_ok = (tidx_wide < TIW'(NUM_TASKS));
    assign load_idx = IDX_W'(tidx_wide);
    assign burst_wide = BW'(cmd.burst_time);
    assign time_max_wide = BW'({TIME_BITS{1'b1}});
    assign load_val = (burst_wide > time_max_wide) ? TIME_BITS'(time_max_wide)
                                                   : TIME_BITS'(burst_wide);

    assign scan_ptr_inc = (scan_ptr_reg == IDX_W'(NUM_TASKS - 1)) ? '0 : scan_ptr_reg + 1'b1;
    assign scan_rem = rem_reg[scan_ptr_reg];
    assign scan_found = (scan_rem != '0);

    always_comb
    begin
        state_next          = state_reg;
        rem_next            = rem_reg;
        level_next          = level_reg;
        next_ptr_next       = next_ptr_reg;
        scan_ptr_next       = scan_ptr_reg;
        active_cnt_next     = active_cnt_reg;
        quantum_first_next  = quantum_first_reg;
        quantum_second_next = quantum_second_reg;
        res_valid_next      = res_valid_reg && !res.ready;
        res_ran_next        = res_ran_reg;
        res_task_next       = res_task_reg;
        res_spent_next      = res_spent_reg;
        res_left_next       = res_left_reg;
        res_finished_next   = res_finished_reg;
        res_all_done_next   = res_all_done_reg;

        if (cfg_write)
        begin
            unique case (paddr[2])
                qrr_pkg::CFG_IDX_QUANTUM_FIRST:  quantum_first_next = pwdata[7:0];
                qrr_pkg::CFG_IDX_QUANTUM_SECOND: quantum_second_next = pwdata[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            STATE_IDLE:
            begin
                if (cmd_xfer)
                begin
                    if (cmd.command == qrr_pkg::CMD_STEP)
                    begin
                        scan_ptr_next = next_ptr_reg;
                        state_next    = STATE_SCAN;
                    end
                    else if (load_ok)
                    begin
                        rem_next[load_idx]   = load_val;
                        level_next[load_idx] = 1'b0;
                        if ((rem_reg[load_idx] == '0) && (load_val != '0))
                            active_cnt_next = active_cnt_reg + 1'b1;
                        else if ((rem_reg[load_idx] != '0) && (load_val == '0))
                            active_cnt_next = active_cnt_reg - 1'b1;
                    end
                end
            end
            STATE_SCAN:
            begin
                if (active_cnt_reg == '0)
                begin
                    if (out_free)
                    begin
                        res_valid_next    = 1'b1;
                        res_ran_next      = 1'b0;
                        res_task_next     = '0;
                        res_spent_next    = '0;
                        res_left_next     = '0;
                        res_finished_next = 1'b0;
                        res_all_done_next = 1'b1;
                        state_next        = STATE_IDLE;
                    end
                end
                else if (scan_found)
                begin
                    if (out_free)
                    begin
                        rem_next[scan_ptr_reg] = slice_left;
                        if (!slice_finished)
                            level_next[scan_ptr_reg] = 1'b1;
                        if (slice_finished)
                            active_cnt_next = active_cnt_reg - 1'b1;
                        next_ptr_next     = scan_ptr_inc;
                        res_valid_next    = 1'b1;
                        res_ran_next      = 1'b1;
                        res_task_next     = qrr_pkg::TASK_IDX_W'(scan_ptr_reg);
                        res_spent_next    = qrr_pkg::FIELD_TIME_W'(slice_spent);
                        res_left_next     = qrr_pkg::FIELD_TIME_W'(slice_left);
                        res_finished_next = slice_finished;
                        res_all_done_next = slice_finished && (active_cnt_reg == CNT_W'(1));
                        state_next        = STATE_IDLE;
                    end
                end
                else
                begin
                    scan_ptr_next = scan_ptr_inc;
                end
            end
            default: state_next = STATE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= STATE_IDLE;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                rem_reg[i] <= '0;
            end
            level_reg          <= '0;
            next_ptr_reg       <= '0;
            scan_ptr_reg       <= '0;
            active_cnt_reg     <= '0;
            quantum_first_reg  <= qrr_pkg::QUANTUM_FIRST_RST;
            quantum_second_reg <= qrr_pkg::QUANTUM_SECOND_RST;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            rem_reg            <= rem_next;
            level_reg          <= level_next;
            next_ptr_reg       <= next_ptr_next;
            scan_ptr_reg       <= scan_ptr_next;
            active_cnt_reg     <= active_cnt_next;
            quantum_first_reg  <= quantum_first_next;
            quantum_second_reg <= quantum_second_next;
            res_valid_reg      <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ran_reg      <= res_ran_next;
        res_task_reg     <= res_task_next;
        res_spent_reg    <= res_spent_next;
        res_left_reg     <= res_left_next;
        res_finished_reg <= res_finished_next;
        res_all_done_reg <= res_all_done_next;
    end

    always_comb
    begin
        unique case (paddr[2])
            qrr_pkg::CFG_IDX_QUANTUM_FIRST:
                prdata = qrr_pkg::APB_DATA_W'(quantum_first_reg);
            qrr_pkg::CFG_IDX_QUANTUM_SECOND:
                prdata = qrr_pkg::APB_DATA_W'(quantum_second_reg);
            default:
                prdata = '0;
        endcase
    end

    assign res.valid       = res_valid_reg;
    assign res.ran         = res_ran_reg;
    assign res.served_task = res_task_reg;
    assign res.time_spent  = res_spent_reg;
    assign res.time_left   = res_left_reg;
    assign res.finished    = res_finished_reg;
    assign res.all_done    = res_all_done_reg;

endmodule

### hdl/qrr_checker.sv
// ----------------------------------------------------------------------------
// qrr_checker: port-level checks for the round-robin core
// Watches the command and result channels and flags inconsistent results.
// ----------------------------------------------------------------------------
module qrr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_ready,
    input  logic                                cmd_command,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  logic                                res_ran,
    input  logic [qrr_pkg::TASK_IDX_W-1:0]      res_served_task,
    input  logic [qrr_pkg::FIELD_TIME_W-1:0]    res_time_spent,
    input  logic [qrr_pkg::FIELD_TIME_W-1:0]    res_time_left,
    input  logic                                res_finished,
    input  logic                                res_all_done
);

    // A waiting result stays valid and keeps its served task, time spent and time left until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_time_spent)
            && $stable(res_time_left) && $stable(res_served_task))
        else $error("result changed while stalled");

    // An accepted step takes command ready low once its scan has begun.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_command == qrr_pkg::CMD_STEP) |=> !cmd_ready)
        else $error("command accepted during a step");

    // An empty step reports all done with every other field cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ran |-> res_all_done && !res_finished
            && (res_served_task == '0) && (res_time_spent == '0) && (res_time_left == '0))
        else $error("empty step result is malformed");

    // A served task always gets time, and finishes exactly when none is left.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ran |-> (res_time_spent != '0)
            && (res_finished == (res_time_left == '0)))
        else $error("served task result is inconsistent");

    // A task that still has time left rules out all done.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ran && !res_finished |-> !res_all_done)
        else $error("all done reported with time left");

endmodule

bind two_level_quantum_round_robin_core qrr_checker u_qrr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_command     (cmd.command),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_ran         (res.ran),
    .res_served_task (res.served_task),
    .res_time_spent  (res.time_spent),
    .res_time_left   (res.time_left),
    .res_finished    (res.finished),
    .res_all_done    (res.all_done)
);

### test/qrr_grant_checker.sv
// ----------------------------------------------------------------------------
// qrr_grant_checker: grant predictor and result comparator
// Watches the command, result and register ports of the round-robin core.
// It keeps its own task table and quanta, works out the grant of every
// step command, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module qrr_grant_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    qrr_cmd_if                                cmd,
    qrr_res_if                                res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [qrr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qrr_pkg::APB_DATA_W-1:0]    pwdata,
    output int                                mismatches,
    output int                                outstanding
);

    localparam int NTASK = qrr_pkg::NUM_TASKS_DEF;

    typedef struct packed {
        logic                                ran;
        logic [qrr_pkg::TASK_IDX_W-1:0]      served;
        logic [qrr_pkg::FIELD_TIME_W-1:0]    spent;
        logic [qrr_pkg::FIELD_TIME_W-1:0]    left;
        logic                                finished;
        logic                                all_done;
    } grant_t;

    logic [qrr_pkg::FIELD_TIME_W-1:0]  time_table [NTASK];
    logic                              level_table [NTASK];
    logic [qrr_pkg::TASK_IDX_W-1:0]    scan_start;
    logic [qrr_pkg::QUANTUM_W-1:0]     slice_first;
    logic [qrr_pkg::QUANTUM_W-1:0]     slice_second;
    grant_t                            grants_due [$];

    function automatic grant_t serve_next();
        grant_t                            g;
        int                                pick;
        int                                cand;
        logic [qrr_pkg::QUANTUM_W-1:0]     slice;
        g = '0;
        pick = -1;
        for (int k = 0; k < NTASK; k++)
        begin
            cand = (int'(scan_start) + k) % NTASK;
            if (pick < 0 && time_table[cand] != 0)
                pick = cand;
        end
        if (pick < 0)
        begin
            g.all_done = 1'b1;
            return g;
        end
        slice = level_table[pick] ? slice_second : slice_first;
        if (slice == 0)
            slice = qrr_pkg::QUANTUM_W'(1);
        g.ran = 1'b1;
        g.served = qrr_pkg::TASK_IDX_W'(pick);
        g.spent = (time_table[pick] < slice) ? time_table[pick] : slice;
        g.left = time_table[pick] - g.spent;
        g.finished = (g.left == 0);
        time_table[pick] = g.left;
        if (g.left != 0)
            level_table[pick] = 1'b1;
        scan_start = qrr_pkg::TASK_IDX_W'((pick + 1) % NTASK);
        g.all_done = 1'b1;
        for (int k = 0; k < NTASK; k++)
        begin
            if (time_table[k] != 0)
                g.all_done = 1'b0;
        end
        return g;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input int want, input logic [31:0] got);
        if (got !== 32'(want))
            report($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        if (!rst_n)
        begin
            for (int k = 0; k < NTASK; k++)
            begin
                time_table[k] = '0;
                level_table[k] = 1'b0;
            end
            scan_start = '0;
            slice_first = qrr_pkg::QUANTUM_FIRST_RST;
            slice_second = qrr_pkg::QUANTUM_SECOND_RST;
            grants_due.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (grants_due.size() == 0)
                    report("result transfer with no grant pending");
                else
                begin
                    g = grants_due.pop_front();
                    check_field("ran", g.ran, 32'(res.ran));
                    check_field("served_task", g.served, 32'(res.served_task));
                    check_field("time_spent", g.spent, 32'(res.time_spent));
                    check_field("time_left", g.left, 32'(res.time_left));
                    check_field("finished", g.finished, 32'(res.finished));
                    check_field("all_done", g.all_done, 32'(res.all_done));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.command == qrr_pkg::CMD_LOAD)
                begin
                    time_table[cmd.task_index] = cmd.burst_time;
                    level_table[cmd.task_index] = 1'b0;
                end
                else
                    grants_due.push_back(serve_next());
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[qrr_pkg::APB_ADDR_W-1:2] == qrr_pkg::CFG_IDX_QUANTUM_FIRST)
                    slice_first = pwdata[qrr_pkg::QUANTUM_W-1:0];
                else if (paddr[qrr_pkg::APB_ADDR_W-1:2] == qrr_pkg::CFG_IDX_QUANTUM_SECOND)
                    slice_second = pwdata[qrr_pkg::QUANTUM_W-1:0];
            end
            outstanding = grants_due.size();
        end
    end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the two-level quantum round-robin core
// Drives load and step commands with random gaps, stalls the result channel
// at random, and reprograms both quanta between phases, zero and the
// extremes among them. A separate checker predicts and compares the grants.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NTASK = qrr_pkg::NUM_TASKS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 190;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [qrr_pkg::APB_ADDR_W-1:0]      paddr;
    logic [qrr_pkg::APB_DATA_W-1:0]      pwdata;
    logic [qrr_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;
    bit                                  idle_gaps;
    int                                  quiet_cycles;
    int                                  fail_count;
    int                                  pending_grants;
    logic [qrr_pkg::QUANTUM_W-1:0]       first_plan [PHASES] =
        '{8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd2};
    logic [qrr_pkg::QUANTUM_W-1:0]       second_plan [PHASES] =
        '{8'd255, 8'd1, 8'd255, 8'd0, 8'd0, 8'd4};

    qrr_cmd_if cmd_ch ();
    qrr_res_if res_ch ();

    two_level_quantum_round_robin_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qrr_grant_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (fail_count),
        .outstanding (pending_grants)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
        res_ch.ready <= !idle_gaps || ($urandom_range(0, 99) >= 36);

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("two_level_quantum_round_robin_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue(input logic op, input logic [qrr_pkg::TASK_IDX_W-1:0] idx,
                         input logic [qrr_pkg::FIELD_TIME_W-1:0] burst);
        while (idle_gaps && $urandom_range(0, 99) < 36)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.task_index <= idx;
        cmd_ch.burst_time <= burst;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_grants != 0)
            @(posedge clk);
        repeat (NTASK + 4) @(posedge clk);
    endtask

    task automatic write_quantum(input logic reg_idx,
                                 input logic [qrr_pkg::QUANTUM_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {24'($urandom_range(0, 32'hFFFFFF)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [qrr_pkg::FIELD_TIME_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return qrr_pkg::FIELD_TIME_W'($urandom_range(1, 24));
        else if (r < 90)
            return qrr_pkg::FIELD_TIME_W'($urandom_range(0, 255));
        else
            return '0;
    endfunction

    task automatic run_batches(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            repeat ($urandom_range(1, NTASK))
            begin
                issue(qrr_pkg::CMD_LOAD, qrr_pkg::TASK_IDX_W'($urandom), pick_burst());
                sent++;
            end
            repeat ($urandom_range(2, 40))
            begin
                if ($urandom_range(0, 99) < 8)
                    issue(qrr_pkg::CMD_LOAD, qrr_pkg::TASK_IDX_W'($urandom),
                          pick_burst());
                else
                    issue(qrr_pkg::CMD_STEP, qrr_pkg::TASK_IDX_W'($urandom),
                          qrr_pkg::FIELD_TIME_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= qrr_pkg::CMD_LOAD;
        cmd_ch.task_index <= '0;
        cmd_ch.burst_time <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        idle_gaps = 1'b1;
        first_plan[4] = qrr_pkg::QUANTUM_W'($urandom_range(0, 255));
        second_plan[4] = qrr_pkg::QUANTUM_W'($urandom_range(0, 255));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty table first, then loads at both ends of the table and the
        // burst range, demotion, reload of a demoted task, and wraparound.
        issue(qrr_pkg::CMD_STEP, 3'd0, 8'd0);
        issue(qrr_pkg::CMD_LOAD, 3'd0, 8'd255);
        issue(qrr_pkg::CMD_LOAD, 3'd7, 8'd1);
        issue(qrr_pkg::CMD_LOAD, 3'd3, 8'd0);
        issue(qrr_pkg::CMD_LOAD, 3'd5, 8'd128);
        repeat (4) issue(qrr_pkg::CMD_STEP, 3'd7, 8'd255);
        issue(qrr_pkg::CMD_LOAD, 3'd0, 8'd3);
        repeat (3) issue(qrr_pkg::CMD_STEP, 3'd2, 8'd170);
        issue(qrr_pkg::CMD_LOAD, 3'd6, 8'd170);
        issue(qrr_pkg::CMD_LOAD, 3'd1, 8'd85);
        settle();

        // Zero quanta must still grant one unit per step.
        write_quantum(qrr_pkg::CFG_IDX_QUANTUM_FIRST, 8'd0);
        write_quantum(qrr_pkg::CFG_IDX_QUANTUM_SECOND, 8'd0);
        repeat (4) issue(qrr_pkg::CMD_STEP, 3'd5, 8'd85);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_gaps = (p != 1);
            write_quantum(qrr_pkg::CFG_IDX_QUANTUM_FIRST, first_plan[p]);
            write_quantum(qrr_pkg::CFG_IDX_QUANTUM_SECOND, second_plan[p]);
            run_batches(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0)
            $display("two_level_quantum_round_robin_core test passed");
        else
            $display("two_level_quantum_round_robin_core test failed");
        $finish;
    end

endmodule

### files.f
hdl/qrr_pkg.sv
hdl/qrr_ifs.sv
hdl/qrr_slice_unit.sv
hdl/two_level_quantum_round_robin_core.sv
hdl/qrr_checker.sv
test/qrr_grant_checker.sv
test/tb_top.sv
